FILE: hdl/fcsb_pkg.sv
package fcsb_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned NRM_W    = 11;
  localparam int unsigned DST_W    = 28;
  localparam int unsigned PROD_W   = COORD_W + NRM_W;
  localparam int unsigned DIST_W   = 40;
  localparam int unsigned FRAC_SH  = 10;
  localparam int unsigned TOL_W    = 8;
  localparam int unsigned PLANE_W  = 64;
  localparam int unsigned NRM_LSB  = DST_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  typedef logic [PLANE_W-1:0]        plane_t;

  typedef enum logic {
    FUNC_SPHERE = 1'b0,
    FUNC_BOX    = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

FILE: hdl/fcsb_dist.sv
module fcsb_dist
  import fcsb_pkg::*;
(
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  func_e    func_i,
  input  coord_t   lo_i [3],
  input  coord_t   hi_i [3],
  input  plane_t   plane_i,
  output dist_t    dist_p_o,
  output dist_t    dist_n_o
);

  logic signed [NRM_W-1:0] nrm [3];
  coord_t pv [3];
  coord_t nv [3];
  prod_t  prod_p_d [3];
  prod_t  prod_n_d [3];
  prod_t  prod_p_q [3];
  prod_t  prod_n_q [3];
  logic signed [DST_W-1:0] dplane;
  dist_t  dist_p_d, dist_n_d, dist_p_q, dist_n_q, dscaled;

  // vertex select and products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nrm[k] = plane_i[NRM_LSB + k*NRM_W +: NRM_W];
      pv[k]  = (func_i == FUNC_BOX && !nrm[k][NRM_W-1]) ? hi_i[k] : lo_i[k];
      nv[k]  = nrm[k][NRM_W-1] ? hi_i[k] : lo_i[k];
      prod_p_d[k] = nrm[k] * pv[k];
      prod_n_d[k] = nrm[k] * nv[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_p_q <= prod_p_d;
      prod_n_q <= prod_n_d;
    end
  end

  // sum and plane offset
  always_comb begin
    dplane   = plane_i[DST_W-1:0];
    dscaled  = DIST_W'(dplane) <<< FRAC_SH;
    dist_p_d = DIST_W'(prod_p_q[0]) + DIST_W'(prod_p_q[1]) + DIST_W'(prod_p_q[2]) - dscaled;
    dist_n_d = DIST_W'(prod_n_q[0]) + DIST_W'(prod_n_q[1]) + DIST_W'(prod_n_q[2]) - dscaled;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      dist_p_q <= dist_p_d;
      dist_n_q <= dist_n_d;
    end
  end

  assign dist_p_o = dist_p_q;
  assign dist_n_o = dist_n_q;

endmodule

FILE: hdl/fcsb_classify.sv
module fcsb_classify
  import fcsb_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic               clk_i,
  input  pipe_en_t           en_i,
  input  func_e              func_i,
  input  logic [COORD_W-1:0] radius_i,
  input  logic [TOL_W-1:0]   tol_i,
  input  dist_t              dist_p_i [PLANE_COUNT],
  input  dist_t              dist_n_i [PLANE_COUNT],
  output verdict_e           verdict_o
);

  localparam int unsigned CNT_W = $clog2(PLANE_COUNT + 1);

  dist_t thr_hi, thr_lo, tol_neg;
  logic [PLANE_COUNT-1:0] out_d, near_d, out_q, near_q;
  func_e func_q;
  logic [CNT_W-1:0] near_cnt;
  verdict_e verdict_d, verdict_q;

  // per-plane compares
  always_comb begin
    thr_hi  = DIST_W'({radius_i, {FRAC_SH{1'b0}}});
    thr_lo  = -thr_hi;
    tol_neg = -DIST_W'(tol_i);
    for (int i = 0; i < PLANE_COUNT; i++) begin
      if (func_i == FUNC_BOX) begin
        out_d[i]  = dist_p_i[i] < tol_neg;
        near_d[i] = dist_n_i[i] < tol_neg;
      end else begin
        out_d[i]  = dist_p_i[i] < thr_lo;
        near_d[i] = dist_p_i[i] < thr_hi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      out_q  <= out_d;
      near_q <= near_d;
      func_q <= func_i;
    end
  end

  // reduce to verdict
  always_comb begin
    near_cnt = '0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      near_cnt = near_cnt + CNT_W'(near_q[i]);
    end
    if (|out_q) begin
      verdict_d = VERDICT_OUTSIDE;
    end else if (func_q == FUNC_BOX) begin
      verdict_d = (near_cnt >= CNT_W'(2)) ? VERDICT_INTERSECT : VERDICT_INSIDE;
    end else begin
      verdict_d = (|near_q) ? VERDICT_INTERSECT : VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      verdict_q <= verdict_d;
    end
  end

  assign verdict_o = verdict_q;

endmodule

FILE: hdl/frustum_cull_sphere_box_top.sv
// Frustum culling unit: classifies a bounding sphere (func 0) or an axis-aligned
// box (func 1) against the PLANE_COUNT programmed planes (six by default) and
// returns inside, intersecting or outside. One request is taken every clock
// cycle while the output side does not stall; each result passes through four
// register stages (products, distance sums, plane compares, verdict) before it
// is valid at the output.
// Planes and box tolerance are written through the plain register port and
// must only change while no request is in flight.
module frustum_cull_sphere_box_top
  import fcsb_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [$clog2(PLANE_COUNT + 2)-1:0]    cfg_idx_i,
  input  logic [PLANE_W-1:0]                    cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic signed [COORD_W-1:0]             point_x_i,
  input  logic signed [COORD_W-1:0]             point_y_i,
  input  logic signed [COORD_W-1:0]             point_z_i,
  input  logic signed [COORD_W-1:0]             upper_x_i,
  input  logic signed [COORD_W-1:0]             upper_y_i,
  input  logic signed [COORD_W-1:0]             upper_z_i,
  input  logic [COORD_W-1:0]                    sphere_radius_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            verdict_o
);

  localparam int unsigned IDX_W = $clog2(PLANE_COUNT + 2);
  localparam logic [IDX_W-1:0] TOL_IDX = IDX_W'(PLANE_COUNT);

  plane_t plane_q [PLANE_COUNT];
  logic [TOL_W-1:0] tol_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_q[i] <= '0;
      end
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (cfg_idx_i == IDX_W'(i)) begin
          plane_q[i] <= cfg_data_i;
        end
      end
      if (cfg_idx_i == TOL_IDX) begin
        tol_q <= cfg_data_i[TOL_W-1:0];
      end
    end
  end

  // pipeline valids and stall control
  logic v1_q, v2_q, v3_q, v4_q;
  pipe_en_t en;

  always_comb begin
    en.s4 = !v4_q || out_ready_i;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  assign in_ready_o  = en.s1;
  assign out_valid_o = v4_q;

  // sideband through the pipe
  func_e func_in, func1_q, func2_q;
  logic [COORD_W-1:0] rad1_q, rad2_q;

  assign func_in = func_e'(func_i);

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      func1_q <= func_in;
      rad1_q  <= sphere_radius_i;
    end
    if (en.s2) begin
      func2_q <= func1_q;
      rad2_q  <= rad1_q;
    end
  end

  coord_t lo [3];
  coord_t hi [3];

  assign lo[0] = point_x_i;
  assign lo[1] = point_y_i;
  assign lo[2] = point_z_i;
  assign hi[0] = upper_x_i;
  assign hi[1] = upper_y_i;
  assign hi[2] = upper_z_i;

  dist_t dist_p [PLANE_COUNT];
  dist_t dist_n [PLANE_COUNT];

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
    fcsb_dist u_dist (
      .clk_i    (clk_i),
      .en_i     (en),
      .func_i   (func_in),
      .lo_i     (lo),
      .hi_i     (hi),
      .plane_i  (plane_q[g]),
      .dist_p_o (dist_p[g]),
      .dist_n_o (dist_n[g])
    );
  end

  verdict_e verdict;

  fcsb_classify #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_classify (
    .clk_i     (clk_i),
    .en_i      (en),
    .func_i    (func2_q),
    .radius_i  (rad2_q),
    .tol_i     (tol_q),
    .dist_p_i  (dist_p),
    .dist_n_i  (dist_n),
    .verdict_o (verdict)
  );

  assign verdict_o = verdict;

endmodule

FILE: tb/sv/fcsb_verdict_checker.sv
module fcsb_verdict_checker
  import fcsb_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned TOL_INDEX   = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [$clog2(PLANE_COUNT + 2)-1:0] cfg_idx_i,
  input  logic [PLANE_W-1:0]                 cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               func_i,
  input  coord_t                             point_x_i,
  input  coord_t                             point_y_i,
  input  coord_t                             point_z_i,
  input  coord_t                             upper_x_i,
  input  coord_t                             upper_y_i,
  input  coord_t                             upper_z_i,
  input  logic [COORD_W-1:0]                 sphere_radius_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [1:0]                         verdict_i,
  output int                                 mismatches_o,
  output int                                 due_o
);

  plane_t           planes [PLANE_COUNT];
  logic [TOL_W-1:0] box_tol;
  verdict_e         due_verdicts [$];

  function automatic bit normal_negative(plane_t pl, int axis);
    return pl[NRM_LSB + axis * NRM_W + NRM_W - 1];
  endfunction

  // signed distance of a point from the plane, Q.10
  function automatic longint plane_offset(plane_t pl, longint vx, longint vy, longint vz);
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic signed [DST_W-1:0] dd;
    longint                  ax, ay, az, ad;
    nx = pl[NRM_LSB +: NRM_W];
    ny = pl[NRM_LSB + NRM_W +: NRM_W];
    nz = pl[NRM_LSB + 2 * NRM_W +: NRM_W];
    dd = pl[DST_W-1:0];
    ax = nx;
    ay = ny;
    az = nz;
    ad = dd;
    return ax * vx + ay * vy + az * vz - ad * 1024;
  endfunction

  function automatic verdict_e classify_bound(func_e kind, longint lx, longint ly, longint lz,
                                              longint hx, longint hy, longint hz,
                                              longint rad);
    longint lo [3];
    longint hi [3];
    longint pv [3];
    longint nv [3];
    longint reach, offset, tol_q;
    int     i, k, misses;
    bit     outside, hit;
    lo[0] = lx;
    lo[1] = ly;
    lo[2] = lz;
    hi[0] = hx;
    hi[1] = hy;
    hi[2] = hz;
    reach   = rad * 1024;
    tol_q   = box_tol;
    misses  = 0;
    outside = 1'b0;
    hit     = 1'b0;
    for (i = 0; i < PLANE_COUNT && !outside; i++) begin
      if (kind == FUNC_SPHERE) begin
        offset = plane_offset(planes[i], lo[0], lo[1], lo[2]);
        if (offset < -reach) begin
          outside = 1'b1;
        end else if (offset < reach) begin
          hit = 1'b1;
        end
      end else begin
        // zero normal part picks the maximum
        for (k = 0; k < 3; k++) begin
          if (normal_negative(planes[i], k)) begin
            pv[k] = lo[k];
            nv[k] = hi[k];
          end else begin
            pv[k] = hi[k];
            nv[k] = lo[k];
          end
        end
        if (plane_offset(planes[i], pv[0], pv[1], pv[2]) < -tol_q) begin
          outside = 1'b1;
        end else if (plane_offset(planes[i], nv[0], nv[1], nv[2]) < -tol_q) begin
          misses++;
        end
      end
    end
    if (outside) return VERDICT_OUTSIDE;
    if (kind == FUNC_SPHERE) return hit ? VERDICT_INTERSECT : VERDICT_INSIDE;
    return (misses >= 2) ? VERDICT_INTERSECT : VERDICT_INSIDE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_e want;
    if (!rst_ni) begin
      foreach (planes[i]) planes[i] = '0;
      box_tol = TOL_RESET;
      due_verdicts.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < PLANE_COUNT) begin
          planes[cfg_idx_i] = cfg_data_i;
        end else if (cfg_idx_i == TOL_INDEX) begin
          box_tol = cfg_data_i[TOL_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_verdicts.push_back(classify_bound(func_e'(func_i), point_x_i, point_y_i, point_z_i,
                                              upper_x_i, upper_y_i, upper_z_i,
                                              sphere_radius_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_verdicts.size() == 0) begin
          mismatches_o++;
          $display("%0t: verdict with no request pending, expected none, got %0d",
                   $time, verdict_i);
        end else begin
          want = due_verdicts.pop_front();
          if (verdict_i !== want) begin
            mismatches_o++;
            $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want, verdict_i);
          end
        end
      end
    end
    due_o = due_verdicts.size();
  end

endmodule

FILE: tb/sv/tb_frustum_cull_sphere_box_top.sv
module tb_frustum_cull_sphere_box_top;
  import fcsb_pkg::*;

  localparam int unsigned PLANES = 6;
  localparam int unsigned IDX_W  = $clog2(PLANES + 2);

  localparam logic [IDX_W-1:0] REG_PLANE_LEFT = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_TOL    = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNUSED     = 3'd7;

  localparam coord_t COORD_MAX      = 24'sh7FFFFF;
  localparam coord_t COORD_MIN      = 24'sh800000;
  localparam int     DIR_EXT        = 4096;
  localparam int     RX_HOLD_CYCLES = 200;
  localparam int     PHASES         = 8;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [IDX_W-1:0]   cfg_idx       = '0;
  plane_t             cfg_data      = '0;
  logic               in_valid      = 1'b0;
  func_e              req_func      = FUNC_SPHERE;
  coord_t             point_x       = '0;
  coord_t             point_y       = '0;
  coord_t             point_z       = '0;
  coord_t             upper_x       = '0;
  coord_t             upper_y       = '0;
  coord_t             upper_z       = '0;
  logic [COORD_W-1:0] sphere_radius = '0;
  logic               out_ready     = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         verdict;

  int mismatch_count;
  int verdicts_due;
  int cur_ext   = DIR_EXT;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit rx_hold   = 1'b0;

  always #10 clk_i = ~clk_i;

  frustum_cull_sphere_box_top #(
    .PLANE_COUNT(PLANES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (req_func),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .point_z_i      (point_z),
    .upper_x_i      (upper_x),
    .upper_y_i      (upper_y),
    .upper_z_i      (upper_z),
    .sphere_radius_i(sphere_radius),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .verdict_o      (verdict)
  );

  fcsb_verdict_checker #(
    .PLANE_COUNT(PLANES),
    .TOL_INDEX  (REG_BOX_TOL)
  ) u_verdict_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (req_func),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .point_z_i      (point_z),
    .upper_x_i      (upper_x),
    .upper_y_i      (upper_y),
    .upper_z_i      (upper_z),
    .sphere_radius_i(sphere_radius),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .verdict_i      (verdict),
    .mismatches_o   (mismatch_count),
    .due_o          (verdicts_due)
  );

  function automatic int draw_idle();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input plane_t data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // drop valid and wait until every verdict is back
  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    wait (verdicts_due == 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_bound(input func_e kind, input coord_t lx, input coord_t ly,
                            input coord_t lz, input coord_t hx, input coord_t hy,
                            input coord_t hz, input logic [COORD_W-1:0] rad);
    int gap;
    gap = tx_steady ? 0 : draw_idle();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_func      = kind;
    point_x       = lx;
    point_y       = ly;
    point_z       = lz;
    upper_x       = hx;
    upper_y       = hy;
    upper_z       = hz;
    sphere_radius = rad;
    in_valid      = 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // axis-aligned frustum of half size ext, optionally with tilted normals
  task automatic program_frustum(input int ext, input bit tilted, input logic [TOL_W-1:0] tol);
    logic signed [NRM_W-1:0] nrm [3];
    logic [2:0]              junk;
    int                      i, k, t, mag, na, d;
    for (i = 0; i < PLANES; i++) begin
      for (k = 0; k < 3; k++) begin
        t      = tilted ? int'($urandom_range(0, 128)) - 64 : 0;
        nrm[k] = t[NRM_W-1:0];
      end
      mag = tilted ? $urandom_range(700, 1023) : 1023;
      if (i % 2 == 0) begin
        na = mag;
      end else begin
        na = (tilted && $urandom_range(0, 3) == 0) ? -1024 : -mag;
      end
      nrm[i / 2] = na[NRM_W-1:0];
      d    = -(((na < 0) ? -na : na) * ext >>> 10);
      junk = 3'($urandom);
      write_reg(REG_PLANE_LEFT + IDX_W'(i), {junk, nrm[2], nrm[1], nrm[0], d[DST_W-1:0]});
    end
    write_reg(REG_BOX_TOL, {{(PLANE_W - TOL_W){1'b0}}, tol});
    cur_ext = ext;
  endtask

  task automatic send_random_bound();
    coord_t             lo [3];
    coord_t             hi [3];
    coord_t             tmp;
    logic [COORD_W-1:0] rad;
    func_e              kind;
    int                 k, span, v, w;
    kind = func_e'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) begin
      for (k = 0; k < 3; k++) begin
        lo[k] = coord_t'($urandom);
        hi[k] = coord_t'($urandom);
      end
      rad = COORD_W'($urandom);
    end else begin
      span = 3 * cur_ext;
      for (k = 0; k < 3; k++) begin
        v     = int'($urandom_range(0, span)) - span / 2;
        w     = v + int'($urandom_range(0, cur_ext));
        lo[k] = coord_t'(v);
        hi[k] = coord_t'(w);
      end
      if ($urandom_range(0, 15) == 0) begin
        k     = $urandom_range(0, 2);
        tmp   = lo[k];
        lo[k] = hi[k];
        hi[k] = tmp;
      end
      rad = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 2 * cur_ext))
                                         : COORD_W'($urandom_range(0, cur_ext / 2));
    end
    send_bound(kind, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], rad);
  endtask

  // result side
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        @(negedge clk_i);
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      stall = rx_steady ? 0 : draw_idle();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int p, i;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // planes still at reset
    send_bound(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, '0);
    send_bound(FUNC_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
               '1);
    send_bound(FUNC_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, '1);
    settle();

    // unused index must not disturb anything
    write_reg(REG_UNUSED, '1);
    program_frustum(DIR_EXT, 1'b0, 8'd0);
    send_bound(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 24'd16);
    send_bound(FUNC_SPHERE, 4090, 0, 0, 0, 0, 0, 24'd64);
    send_bound(FUNC_SPHERE, 12288, 0, 0, 0, 0, 0, 24'd0);
    send_bound(FUNC_SPHERE, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 24'd0);
    send_bound(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, '1);
    send_bound(FUNC_BOX, -1024, -1024, -1024, 1024, 1024, 1024, '0);
    send_bound(FUNC_BOX, -1024, -1024, -1024, 8192, 1024, 1024, '0);
    send_bound(FUNC_BOX, -8192, -1024, -1024, 8192, 1024, 1024, '0);
    send_bound(FUNC_BOX, 8192, 0, 0, 12288, 1024, 1024, '0);
    // min above max
    send_bound(FUNC_BOX, 2048, 2048, 2048, -2048, -2048, -2048, '0);
    send_bound(FUNC_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, '0);
    send_bound(FUNC_BOX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '0);
    settle();

    // all-ones planes: offset is 1024 - (x + y + z), tolerance decides
    for (i = 0; i < PLANES; i++) write_reg(REG_PLANE_LEFT + IDX_W'(i), '1);
    write_reg(REG_BOX_TOL, {{(PLANE_W - TOL_W){1'b0}}, 8'd255});
    send_bound(FUNC_BOX, 408, 408, 408, 500, 500, 500, '0);
    send_bound(FUNC_BOX, 400, 400, 480, 500, 500, 500, '0);
    settle();
    write_reg(REG_BOX_TOL, '0);
    send_bound(FUNC_BOX, 408, 408, 408, 500, 500, 500, '0);
    settle();

    for (p = 0; p < PHASES; p++) begin
      settle();
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      case (p)
        1: begin
          for (i = 0; i < PLANES; i++) write_reg(REG_PLANE_LEFT + IDX_W'(i), '1);
          write_reg(REG_BOX_TOL, {{(PLANE_W - TOL_W){1'b0}}, 8'd255});
          cur_ext = 1024;
        end
        2: begin
          for (i = 0; i < PLANES; i++) begin
            write_reg(REG_PLANE_LEFT + IDX_W'(i), {$urandom, $urandom});
          end
          write_reg(REG_BOX_TOL, {$urandom, $urandom});
          cur_ext = $urandom_range(64, 1 << 18);
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       program_frustum($urandom_range(64, 1 << 18), 1'b1, 8'd0);
            1:       program_frustum($urandom_range(64, 1 << 18), 1'b1, 8'd255);
            default: program_frustum($urandom_range(64, 1 << 18), 1'b1, TOL_W'($urandom));
          endcase
        end
      endcase
      if (p == 5) begin
        // output held off while requests keep coming
        rx_hold   = 1'b1;
        tx_steady = 1'b1;
        repeat (40) send_random_bound();
        tx_steady = 1'b0;
      end
      repeat (100) send_random_bound();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && verdicts_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fcsb_pkg.sv
hdl/fcsb_dist.sv
hdl/fcsb_classify.sv
hdl/frustum_cull_sphere_box_top.sv
tb/sv/fcsb_verdict_checker.sv
tb/sv/tb_frustum_cull_sphere_box_top.sv
